@@ hdl/vdp_pkg.sv @@
package vdp_pkg;

  // Table geometry
  localparam int MAX_POSES      = 512;
  localparam int FRAC_BITS      = 16;
  localparam int WORDS_PER_POSE = 25;
  localparam int POSE_AW        = $clog2(MAX_POSES);

  // Field widths
  localparam int WORD_W    = 32;
  localparam int POSE_W    = 9;
  localparam int WIDX_W    = 5;
  localparam int CNT_W     = 10;
  localparam int DIM_W     = 2;
  localparam int SCALE_W   = 31;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Datapath widths
  localparam int PROD_W = 2 * WORD_W - FRAC_BITS;  // product after the fraction shift
  localparam int SUM_W  = PROD_W + 2;              // three products plus the constant column
  localparam int SQ_W   = 2 * WORD_W;              // sum of squares
  localparam int QUO_W  = 32;
  localparam int DIV_LAT    = QUO_W + 1;
  localparam int SQRT_STEPS = SQ_W / 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_COUNT = 1'd1;

  localparam logic [DIM_W-1:0] DIM_PLANAR = 2'd2;
  localparam logic [DIM_W-1:0] DIM_RESET  = 2'd3;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  localparam int WORD_EXT_BASE = 12;
  localparam int WORD_SD_DIST  = 24;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POSE_RANGE = 2'd1,
    STATUS_ZERO_DIV   = 2'd2
  } status_e;

endpackage

@@ hdl/vdp_in_if.sv @@
interface vdp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic        [vdp_pkg::POSE_W-1:0]  pose;
  logic        [vdp_pkg::WIDX_W-1:0]  word_index;
  logic signed [vdp_pkg::WORD_W-1:0]  word_value;
  logic signed [vdp_pkg::WORD_W-1:0]  voxel_x;
  logic signed [vdp_pkg::WORD_W-1:0]  voxel_y;
  logic signed [vdp_pkg::WORD_W-1:0]  voxel_z;

  modport source (
    output valid, mode, pose, word_index, word_value, voxel_x, voxel_y, voxel_z,
    input  ready
  );
  modport sink (
    input  valid, mode, pose, word_index, word_value, voxel_x, voxel_y, voxel_z,
    output ready
  );
endinterface

@@ hdl/vdp_out_if.sv @@
interface vdp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vdp_pkg::WORD_W-1:0]   detector_u;
  logic signed [vdp_pkg::WORD_W-1:0]   detector_v;
  logic        [vdp_pkg::POSE_W-1:0]   pose_out;
  logic        [vdp_pkg::SCALE_W-1:0]  scaling;
  logic        [vdp_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, detector_u, detector_v, pose_out, scaling, status,
    input  ready
  );
  modport sink (
    input  valid, detector_u, detector_v, pose_out, scaling, status,
    output ready
  );
endinterface

@@ hdl/vdp_ram.sv @@
module vdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/vdp_div.sv @@
module vdp_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [vdp_pkg::SUM_W-1:0]  num_i,
  input  logic [vdp_pkg::SUM_W-1:0]  den_i,
  output logic [vdp_pkg::QUO_W-1:0]  quo_o,
  output logic                       big_o
);

  localparam int SW = vdp_pkg::SUM_W;
  localparam int QW = vdp_pkg::QUO_W;
  localparam int FB = vdp_pkg::FRAC_BITS;

  logic [SW+FB-1:0] dvd;
  logic [SW-1:0]    rem_q [QW];
  logic [QW-1:0]    low_q [QW];
  logic [SW-1:0]    den_q [QW];
  logic [QW-1:0]    quo_q [QW+1];
  logic             big_q [QW+1];

  assign dvd = {num_i, {FB{1'b0}}};

  // Entry: quotient is known to fit in QW bits unless num >= den * 2^(QW-FB)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= SW'(dvd >> QW);
      low_q[0] <= dvd[QW-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      big_q[0] <= ((SW + QW)'(dvd) >= {den_i, {QW{1'b0}}});
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [SW:0] trial;
    logic        fit;

    assign trial = {rem_q[k], low_q[k][QW-1]};
    assign fit   = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k+1] <= {quo_q[k][QW-2:0], fit};
        big_q[k+1] <= big_q[k];
      end
    end

    if (k < QW - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= fit ? SW'(trial - {1'b0, den_q[k]}) : SW'(trial);
          low_q[k+1] <= low_q[k] << 1;
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign big_o = big_q[QW];

endmodule

@@ hdl/voxel_to_detector_projection.sv @@
// Voxel to detector projection. Load beats (mode 0) write one word of the
// per-pose geometry table; project beats (mode 1) map a voxel through the
// pose's projection matrix with a perspective divide, and through its
// extrinsic matrix to a camera distance whose integer square root scales the
// source-detector distance. The block takes one beat per cycle while the
// output is not held, loads and projects mixed freely, and passes each
// project through datapath stages A to E, a 32-step square root pipeline,
// a 33-stage divider and the output register; the rate is set by the table,
// which is 25 single-port RAMs of MAX_POSES words, one per table word, so one
// beat is either one write or one full-row read. A load is visible to a
// project beat taken in the next cycle. The whole pipeline holds while a
// result waits on the output. Reading a table word that was never loaded
// gives undefined results. dimensions = 2 selects planar geometry (rows 0-1,
// columns 0, 1 and 3); any other value is the volume mode.
module voxel_to_detector_projection (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vdp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vdp_pkg::CNT_W-1:0]         cfg_data_i,
  vdp_in_if.sink                            in_i,
  vdp_out_if.source                         out_o
);

  localparam int WW    = vdp_pkg::WORD_W;
  localparam int PW    = vdp_pkg::PROD_W;
  localparam int SW    = vdp_pkg::SUM_W;
  localparam int NW    = vdp_pkg::WORDS_PER_POSE;
  localparam int SQW   = vdp_pkg::SQ_W;
  localparam int QW    = vdp_pkg::QUO_W;
  localparam int NSQ   = vdp_pkg::SQRT_STEPS;
  localparam int SB_N  = 2 + NSQ + vdp_pkg::DIV_LAT;  // sideband taps from stage D on
  localparam int SQ_END = 1 + NSQ;                    // tap where the norm is ready
  localparam int UV_N  = SB_N - 1 - SQ_END;

  typedef struct packed {
    logic                       valid;
    logic [vdp_pkg::POSE_W-1:0] pose;
    logic                       is3d;
    logic                       oor;
    logic                       den_zero;
    logic                       norm_zero;
    logic                       neg_u;
    logic                       neg_v;
    logic signed [WW-1:0]       sd;
  } side_t;

  typedef struct packed {
    logic [QW-1:0] quo_u;
    logic          big_u;
    logic [QW-1:0] quo_v;
    logic          big_v;
  } uv_t;

  function automatic logic signed [WW-1:0] sat_word(logic signed [SW-1:0] x);
    logic [SW-WW:0] top;
    top = x[SW-1:WW-1];
    if (top == '0 || top == '1) begin
      return x[WW-1:0];
    end
    return x[SW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
  endfunction

  function automatic logic [SW-1:0] mag(logic signed [SW-1:0] x);
    return x[SW-1] ? SW'(-x) : SW'(x);
  endfunction

  // Configuration
  logic [vdp_pkg::DIM_W-1:0] dim_q;
  logic [vdp_pkg::CNT_W-1:0] pose_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q      <= vdp_pkg::DIM_RESET;
      pose_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vdp_pkg::REG_DIMENSIONS: dim_q      <= cfg_data_i[vdp_pkg::DIM_W-1:0];
        vdp_pkg::REG_POSE_COUNT: pose_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipeline moves unless a result is stuck
  logic out_valid_q;
  logic adv;
  logic acc;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;

  // Geometry table: one RAM per table word, addressed by pose
  logic                           load_ok;
  logic                           rd_en;
  logic signed [WW-1:0]           rd [NW];
  logic [vdp_pkg::POSE_AW-1:0]    ram_addr;

  assign load_ok  = (in_i.mode == vdp_pkg::MODE_LOAD) &&
                    (int'(in_i.pose) < vdp_pkg::MAX_POSES) &&
                    (int'(in_i.word_index) < NW);
  assign rd_en    = acc && (in_i.mode == vdp_pkg::MODE_PROJECT);
  assign ram_addr = vdp_pkg::POSE_AW'(in_i.pose);

  for (genvar w = 0; w < NW; w++) begin : g_tab
    logic we;
    logic [WW-1:0] rdata;
    assign we = acc && load_ok && (int'(in_i.word_index) == w);
    vdp_ram #(.WIDTH(WW), .DEPTH(vdp_pkg::MAX_POSES)) u_ram (
      .clk_i   (clk_i),
      .en_i    (we || rd_en),
      .we_i    (we),
      .addr_i  (ram_addr),
      .wdata_i (in_i.word_value),
      .rdata_o (rdata)
    );
    assign rd[w] = $signed(rdata);
  end

  // Stage A: table read in flight, latch the voxel
  logic                       a_valid_q;
  logic [vdp_pkg::POSE_W-1:0] a_pose_q;
  logic                       a_is3d_q;
  logic                       a_oor_q;
  logic signed [WW-1:0]       a_vox_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_pose_q   <= in_i.pose;
      a_is3d_q   <= (dim_q != vdp_pkg::DIM_PLANAR);
      a_oor_q    <= ({1'b0, in_i.pose} >= pose_cnt_q) ||
                    (int'(in_i.pose) >= vdp_pkg::MAX_POSES);
      a_vox_q[0] <= in_i.voxel_x;
      a_vox_q[1] <= in_i.voxel_y;
      a_vox_q[2] <= in_i.voxel_z;
    end
  end

  // Stage B: eighteen products, floor-shifted by the fraction
  logic                       b_valid_q;
  logic [vdp_pkg::POSE_W-1:0] b_pose_q;
  logic                       b_is3d_q;
  logic                       b_oor_q;
  logic signed [PW-1:0]       b_prod_q [6][3];
  logic signed [WW-1:0]       b_k_q [6];
  logic signed [WW-1:0]       b_sd_q;
  logic signed [2*WW-1:0]     prod [6][3];

  always_comb begin
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = rd[4*r+c] * a_vox_q[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_pose_q <= a_pose_q;
      b_is3d_q <= a_is3d_q;
      b_oor_q  <= a_oor_q;
      b_sd_q   <= rd[vdp_pkg::WORD_SD_DIST];
      for (int r = 0; r < 6; r++) begin
        b_k_q[r] <= rd[4*r+3];
        for (int c = 0; c < 3; c++) begin
          b_prod_q[r][c] <= prod[r][c][2*WW-1:vdp_pkg::FRAC_BITS];
        end
      end
    end
  end

  // Stage C: row sums; camera components saturate to a word
  logic                       c_valid_q;
  logic [vdp_pkg::POSE_W-1:0] c_pose_q;
  logic                       c_is3d_q;
  logic                       c_oor_q;
  logic signed [SW-1:0]       c_p_q [3];
  logic signed [WW-1:0]       c_c_q [3];
  logic signed [WW-1:0]       c_sd_q;
  logic signed [SW-1:0]       row_sum [6];

  always_comb begin
    for (int r = 0; r < 6; r++) begin
      row_sum[r] = SW'(b_prod_q[r][0]) + SW'(b_prod_q[r][1]) +
                   (b_is3d_q ? SW'(b_prod_q[r][2]) : SW'(0)) + SW'(b_k_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_pose_q <= b_pose_q;
      c_is3d_q <= b_is3d_q;
      c_oor_q  <= b_oor_q;
      c_sd_q   <= b_sd_q;
      for (int i = 0; i < 3; i++) begin
        c_p_q[i] <= row_sum[i];
        c_c_q[i] <= sat_word(row_sum[vdp_pkg::WORD_EXT_BASE / 4 + i]);
      end
    end
  end

  // Stage D: squares, magnitudes and signs for the perspective divide
  logic [SQW-1:0]       d_sq_q [3];
  logic [SW-1:0]        d_num_q [2];
  logic [SW-1:0]        d_den_q;
  logic signed [SW-1:0] den;
  logic signed [SQW-1:0] sq [3];
  side_t                sb_q [SB_N];

  assign den = c_is3d_q ? c_p_q[2] : c_p_q[1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = c_c_q[i] * c_c_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_sq_q[0]  <= SQW'(sq[0]);
      d_sq_q[1]  <= SQW'(sq[1]);
      d_sq_q[2]  <= c_is3d_q ? SQW'(sq[2]) : '0;
      d_num_q[0] <= mag(c_p_q[0]);
      d_num_q[1] <= mag(c_p_q[1]);
      d_den_q    <= mag(den);
    end
  end

  // Sideband taps; tap 1 picks up the zero-norm flag
  logic [SQW-1:0] sumsq;
  side_t          sb_nz;

  assign sumsq = d_sq_q[0] + d_sq_q[1] + d_sq_q[2];

  always_comb begin
    sb_nz           = sb_q[0];
    sb_nz.norm_zero = (sumsq == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SB_N; i++) begin
        sb_q[i] <= '0;
      end
    end else if (adv) begin
      sb_q[0].valid     <= c_valid_q;
      sb_q[0].pose      <= c_pose_q;
      sb_q[0].is3d      <= c_is3d_q;
      sb_q[0].oor       <= c_oor_q;
      sb_q[0].den_zero  <= (den == '0);
      sb_q[0].norm_zero <= 1'b0;
      sb_q[0].neg_u     <= c_p_q[0][SW-1] ^ den[SW-1];
      sb_q[0].neg_v     <= c_p_q[1][SW-1] ^ den[SW-1];
      sb_q[0].sd        <= c_sd_q;
      sb_q[1]           <= sb_nz;
      for (int i = 2; i < SB_N; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // Stage E and the square root pipeline, one result bit per step
  logic [SQW-1:0] e_sumsq_q;
  logic [SQW-1:0] sq_n_q [NSQ];
  logic [SQW-1:0] sq_r_q [NSQ];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_sumsq_q <= sumsq;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [SQW-1:0] n_in;
    logic [SQW-1:0] r_in;
    logic [SQW-1:0] trial;

    if (k == 0) begin : g_first
      assign n_in = e_sumsq_q;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = sq_n_q[k-1];
      assign r_in = sq_r_q[k-1];
    end

    assign trial = r_in + (SQW'(1) << (SQW - 2 - 2 * k));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (n_in >= trial) begin
          sq_n_q[k] <= n_in - trial;
          sq_r_q[k] <= (r_in >> 1) + (SQW'(1) << (SQW - 2 - 2 * k));
        end else begin
          sq_n_q[k] <= n_in;
          sq_r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  // Perspective divides start at stage D, then wait for the scaling divide
  uv_t            uv_div;
  uv_t            uv_q [UV_N];

  vdp_div u_div_u (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (d_num_q[0]),
    .den_i (d_den_q),
    .quo_o (uv_div.quo_u),
    .big_o (uv_div.big_u)
  );

  vdp_div u_div_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (d_num_q[1]),
    .den_i (d_den_q),
    .quo_o (uv_div.quo_v),
    .big_o (uv_div.big_v)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      uv_q[0] <= uv_div;
      for (int i = 1; i < UV_N; i++) begin
        uv_q[i] <= uv_q[i-1];
      end
    end
  end

  // Scaling divide: distance over norm; drop a non-positive distance
  logic [SW-1:0] sc_num;
  logic [QW-1:0] sc_quo;
  logic          sc_big;

  assign sc_num = (sb_q[SQ_END].sd > 0) ? SW'(unsigned'(sb_q[SQ_END].sd)) : '0;

  vdp_div u_div_s (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sc_num),
    .den_i (SW'(sq_r_q[NSQ-1][WW-1:0])),
    .quo_o (sc_quo),
    .big_o (sc_big)
  );

  // Final saturation and status
  side_t                 fin;
  uv_t                   fin_uv;
  logic [QW-1:0]         lim_u;
  logic [QW-1:0]         lim_v;
  logic [QW-1:0]         mag_u;
  logic [QW-1:0]         mag_v;
  logic [QW-1:0]         scale_max;
  logic [vdp_pkg::SCALE_W-1:0] scale_val;
  vdp_pkg::status_e      status;

  assign fin    = sb_q[SB_N-1];
  assign fin_uv = uv_q[UV_N-1];

  always_comb begin
    lim_u     = fin.neg_u ? (QW'(1) << (WW - 1)) : ((QW'(1) << (WW - 1)) - QW'(1));
    lim_v     = fin.neg_v ? (QW'(1) << (WW - 1)) : ((QW'(1) << (WW - 1)) - QW'(1));
    scale_max = (QW'(1) << vdp_pkg::SCALE_W) - QW'(1);
    mag_u     = (fin_uv.big_u || fin_uv.quo_u > lim_u) ? lim_u : fin_uv.quo_u;
    mag_v     = (fin_uv.big_v || fin_uv.quo_v > lim_v) ? lim_v : fin_uv.quo_v;
    scale_val = (sc_big || sc_quo > scale_max) ? scale_max[vdp_pkg::SCALE_W-1:0]
                                               : sc_quo[vdp_pkg::SCALE_W-1:0];
    if (fin.oor) begin
      status = vdp_pkg::STATUS_POSE_RANGE;
    end else if (fin.den_zero || fin.norm_zero) begin
      status = vdp_pkg::STATUS_ZERO_DIV;
    end else begin
      status = vdp_pkg::STATUS_OK;
    end
  end

  // Output register
  logic signed [WW-1:0]           out_u_q;
  logic signed [WW-1:0]           out_v_q;
  logic [vdp_pkg::POSE_W-1:0]     out_pose_q;
  logic [vdp_pkg::SCALE_W-1:0]    out_scale_q;
  logic [vdp_pkg::STATUS_W-1:0]   out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pose_q   <= fin.pose;
      out_status_q <= status;
      if (status != vdp_pkg::STATUS_OK) begin
        out_u_q     <= '0;
        out_v_q     <= '0;
        out_scale_q <= '0;
      end else begin
        out_u_q     <= fin.neg_u ? $signed(WW'(-mag_u)) : $signed(WW'(mag_u));
        out_v_q     <= !fin.is3d ? '0 :
                       fin.neg_v ? $signed(WW'(-mag_v)) : $signed(WW'(mag_v));
        out_scale_q <= scale_val;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.detector_u = out_u_q;
  assign out_o.detector_v = out_v_q;
  assign out_o.pose_out   = out_pose_q;
  assign out_o.scaling    = out_scale_q;
  assign out_o.status     = out_status_q;

endmodule

@@ tb/tb_voxel_to_detector_projection.sv @@
`timescale 1ns / 1ps

module tb_voxel_to_detector_projection;

  // Load beats and project beats are queued by the stimulus process and
  // pushed into the block by the input driver. Each accepted beat updates a
  // local copy of the geometry table, or is projected with the local
  // fixed-point math, and the result is stored as the next awaited result.
  // The output monitor compares every result beat with the oldest awaited one.
  //
  // No project beat ever reads a table word that was never loaded. A pose
  // becomes usable once all 25 of its words have been queued. Out-of-range
  // poses can be projected at any time, since they read nothing.

  localparam int MAX_POSES      = vdp_pkg::MAX_POSES;
  localparam int FRAC_BITS      = vdp_pkg::FRAC_BITS;
  localparam int WORDS_PER_POSE = vdp_pkg::WORDS_PER_POSE;
  localparam int WORD_EXT_BASE  = vdp_pkg::WORD_EXT_BASE;
  localparam int WORD_SD_DIST   = vdp_pkg::WORD_SD_DIST;
  localparam int WORD_W         = vdp_pkg::WORD_W;
  localparam int POSE_W         = vdp_pkg::POSE_W;
  localparam int WIDX_W         = vdp_pkg::WIDX_W;
  localparam int SCALE_W        = vdp_pkg::SCALE_W;
  localparam int STATUS_W       = vdp_pkg::STATUS_W;
  localparam int CNT_W          = vdp_pkg::CNT_W;
  localparam int DIM_W          = vdp_pkg::DIM_W;
  localparam int CFG_IDX_W      = vdp_pkg::CFG_IDX_W;

  localparam int LATENCY    = 90;    // pipeline depth plus margin
  localparam int HANG_LIMIT = 20000; // cycles with no beat taken on either side
  localparam int HOLD_LEN   = 400;   // long output hold-off

  typedef struct packed {
    logic                     mode;
    logic [POSE_W-1:0]        pose;
    logic [WIDX_W-1:0]        widx;
    logic signed [WORD_W-1:0] wval;
    logic signed [WORD_W-1:0] vx;
    logic signed [WORD_W-1:0] vy;
    logic signed [WORD_W-1:0] vz;
  } beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] u;
    logic signed [WORD_W-1:0] v;
    logic [POSE_W-1:0]        pose;
    logic [SCALE_W-1:0]       scaling;
    logic [STATUS_W-1:0]      status;
  } detector_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CNT_W-1:0]   cfg_data_i;

  vdp_in_if  in_if ();
  vdp_out_if out_if ();

  voxel_to_detector_projection u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Stimulus queue, awaited results and shared state.
  beat_t     beat_q[$];
  detector_t det_q[$];
  int        mismatches;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        hold_req;
  int        hold_done;
  int        hold_left;
  int        stall_cycles;

  // Shadow of the block: register copies and the geometry table.
  logic [DIM_W-1:0]  dims_sh;
  logic [CNT_W-1:0]  pcount_sh;
  int                geom[MAX_POSES][WORDS_PER_POSE];

  // Generator bookkeeping: which words of each pose have been queued.
  logic [WORDS_PER_POSE-1:0] queued_words[MAX_POSES];
  int                        full_poses[$];

  // ---------------------------------------------------------------------
  // Fixed-point math of the block
  // ---------------------------------------------------------------------

  // Product term: full product, then floor shift by the fraction width.
  function automatic longint row_dot(int pose, int base, longint vx, longint vy,
                                     longint vz, bit is3d);
    longint s;
    s = (longint'(geom[pose][base]) * vx) >>> FRAC_BITS;
    s += (longint'(geom[pose][base+1]) * vy) >>> FRAC_BITS;
    if (is3d) s += (longint'(geom[pose][base+2]) * vz) >>> FRAC_BITS;
    return s + longint'(geom[pose][base+3]);
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // min(floor(a * 2^FRAC_BITS / b), limit) with b > 0
  function automatic longint unsigned ufix_div(longint unsigned a, longint unsigned b,
                                               longint unsigned limit);
    longint unsigned ip, r, q;
    ip = a / b;
    r  = a % b;
    if (ip > (limit >> FRAC_BITS)) return limit;
    q = ip;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return (q > limit) ? limit : q;
  endfunction

  // Signed quotient, truncated toward zero and saturated to 32 bits.
  function automatic longint sfix_div(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, q;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? $unsigned(-a) : $unsigned(a);
    ub  = (b < 0) ? $unsigned(-b) : $unsigned(b);
    q   = ufix_div(ua, ub, neg ? 64'd2147483648 : 64'd2147483647);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, one_b;
    res   = 0;
    one_b = 64'd1 << 62;
    while (one_b > n) one_b = one_b >> 2;
    while (one_b != 0) begin
      if (n >= res + one_b) begin
        n   = n - (res + one_b);
        res = (res >> 1) + one_b;
      end else begin
        res = res >> 1;
      end
      one_b = one_b >> 2;
    end
    return res;
  endfunction

  // Apply one accepted beat to the shadow; return 1 with the result for projects.
  function automatic bit apply_beat(beat_t b, output detector_t d);
    bit is3d;
    int n, p;
    longint pr[3], c;
    longint unsigned sumsq, norm;
    d = '0;
    if (b.mode == vdp_pkg::MODE_LOAD) begin
      if (int'(b.widx) < WORDS_PER_POSE) geom[b.pose][b.widx] = b.wval;
      return 1'b0;
    end
    p      = int'(b.pose);
    d.pose = b.pose;
    if (p >= int'(pcount_sh) || p >= MAX_POSES) begin
      d.status = vdp_pkg::STATUS_POSE_RANGE;
      return 1'b1;
    end
    is3d  = dims_sh != vdp_pkg::DIM_PLANAR;
    n     = is3d ? 3 : 2;
    sumsq = 0;
    for (int i = 0; i < n; i++) begin
      pr[i] = row_dot(p, 4*i, b.vx, b.vy, b.vz, is3d);
      c     = sat32(row_dot(p, WORD_EXT_BASE + 4*i, b.vx, b.vy, b.vz, is3d));
      sumsq += $unsigned(c * c);
    end
    norm = int_sqrt(sumsq);
    if (pr[n-1] == 0 || norm == 0) begin
      d.status = vdp_pkg::STATUS_ZERO_DIV;
      return 1'b1;
    end
    d.status = vdp_pkg::STATUS_OK;
    d.u      = WORD_W'(sfix_div(pr[0], pr[n-1]));
    if (is3d) d.v = WORD_W'(sfix_div(pr[1], pr[n-1]));
    if (geom[p][WORD_SD_DIST] > 0)
      d.scaling = SCALE_W'(ufix_div($unsigned(longint'(geom[p][WORD_SD_DIST])), norm,
                                    64'd2147483647));
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: hold a beat until taken, then advance or idle at random.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    beat_t     nb;
    detector_t d;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        if (apply_beat({in_if.mode, in_if.pose, in_if.word_index, in_if.word_value,
                        in_if.voxel_x, in_if.voxel_y, in_if.voxel_z}, d))
          det_q.push_back(d);
      end
      if (!in_if.valid || in_if.ready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nb = beat_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.mode       <= nb.mode;
          in_if.pose       <= nb.pose;
          in_if.word_index <= nb.widx;
          in_if.word_value <= nb.wval;
          in_if.voxel_x    <= nb.vx;
          in_if.voxel_y    <= nb.vy;
          in_if.voxel_z    <= nb.vz;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor: check each result beat; drive ready with random stalls
  // and, on request, one long hold-off counted here.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    detector_t got, want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.detector_u, out_if.detector_v, out_if.pose_out, out_if.scaling,
               out_if.status};
        if (det_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result beat u=%0d v=%0d pose=%0d scale=%0d st=%0d",
                     got.u, got.v, got.pose, got.scaling, got.status);
        end else begin
          want = det_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result mismatch");
              $display("  expected u=%0d v=%0d pose=%0d scale=%0d st=%0d",
                       want.u, want.v, want.pose, want.scaling, want.status);
              $display("  actual   u=%0d v=%0d pose=%0d scale=%0d st=%0d",
                       got.u, got.v, got.pose, got.scaling, got.status);
            end
          end
        end
      end
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= HANG_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int rand_q();
    int m;
    case ($urandom_range(7))
      0: return $urandom;
      1: return 0;
      default: begin
        m = $urandom_range(0, 200 << 16);
        return $urandom_range(1) ? m : -m;
      end
    endcase
  endfunction

  function automatic void push_load(int p, int w, int val);
    beat_t b;
    b      = '0;
    b.mode = vdp_pkg::MODE_LOAD;
    b.pose = POSE_W'(p);
    b.widx = WIDX_W'(w);
    b.wval = val;
    b.vx   = $urandom;
    b.vy   = $urandom;
    b.vz   = $urandom;
    if (w < WORDS_PER_POSE) queued_words[p][w] = 1'b1;
    beat_q.push_back(b);
  endfunction

  function automatic void push_project(int p, int x, int y, int z);
    beat_t b;
    b.mode = vdp_pkg::MODE_PROJECT;
    b.pose = POSE_W'(p);
    b.widx = WIDX_W'($urandom);
    b.wval = $urandom;
    b.vx   = x;
    b.vy   = y;
    b.vz   = z;
    beat_q.push_back(b);
  endfunction

  // Load every word of a pose. Kinds: 0 ordinary, 1 zero perspective divisor,
  // 2 zero camera distance, 3 negative source distance, 4 full-range words.
  function automatic void load_pose(int p, int kind);
    int val;
    bit was_full;
    was_full = &queued_words[p];
    for (int w = 0; w < WORDS_PER_POSE; w++) begin
      val = (kind == 4) ? int'($urandom) : rand_q();
      if (kind == 1 && w >= 4 && w < 12) val = 0;
      if (kind == 2 && w >= WORD_EXT_BASE && w < WORD_SD_DIST) val = 0;
      if (w == WORD_SD_DIST)
        val = (kind == 3) ? -int'($urandom_range(1, 32'h7fffffff))
                          : int'($urandom_range(0, 2000 << 16));
      push_load(p, w, val);
    end
    if (!was_full) full_poses.push_back(p);
  endfunction

  // Pick a pose that may be projected: usable and in range, or out of range.
  function automatic int pick_pose(bit want_range);
    int cand[$];
    foreach (full_poses[i])
      if (full_poses[i] < int'(pcount_sh)) cand.push_back(full_poses[i]);
    if (want_range && cand.size() != 0) return cand[$urandom_range(cand.size()-1)];
    if (int'(pcount_sh) < MAX_POSES)
      return int'($urandom_range(int'(pcount_sh), MAX_POSES-1));
    return -1;
  endfunction

  task automatic random_beats(int count);
    int p, k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 2) begin
        load_pose(int'($urandom_range(MAX_POSES-1)), int'($urandom_range(4)));
      end else if (k < 10 && full_poses.size() != 0) begin
        // overwrite one word of a usable pose; it stays usable
        p = full_poses[$urandom_range(full_poses.size()-1)];
        push_load(p, int'($urandom_range(WORDS_PER_POSE-1)), rand_q());
      end else if (k < 14) begin
        // out-of-table word index, dropped by the block
        push_load(int'($urandom_range(MAX_POSES-1)), int'($urandom_range(WORDS_PER_POSE, 31)),
                  int'($urandom));
      end else if (k < 18) begin
        push_load(int'($urandom_range(MAX_POSES-1)), int'($urandom_range(WORDS_PER_POSE-1)),
                  rand_q());
      end else begin
        p = pick_pose($urandom_range(99) < 85);
        if (p < 0) p = pick_pose(1'b1);
        if (p < 0) load_pose(int'($urandom_range(MAX_POSES-1)), 0);
        else push_project(p, rand_q(), rand_q(), rand_q());
      end
    end
  endtask

  // Hold off the sender until every result is back and the pipeline is empty.
  task automatic drain();
    while (beat_q.size() != 0 || in_if.valid || det_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == vdp_pkg::REG_DIMENSIONS) dims_sh = data[DIM_W-1:0];
    else pcount_sh = data;
  endtask

  task automatic run_phase(logic [DIM_W-1:0] dims, logic [CNT_W-1:0] pcount, int count,
                           int tx_pct, int rx_pct, bit long_hold);
    cfg_write(vdp_pkg::REG_DIMENSIONS, CNT_W'(dims));
    cfg_write(vdp_pkg::REG_POSE_COUNT, pcount);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    random_beats(count);
    if (long_hold) hold_req++;
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = vdp_pkg::REG_DIMENSIONS;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = vdp_pkg::MODE_LOAD;
    in_if.pose       = '0;
    in_if.word_index = '0;
    in_if.word_value = '0;
    in_if.voxel_x    = '0;
    in_if.voxel_y    = '0;
    in_if.voxel_z    = '0;
    out_if.ready     = 1'b0;
    mismatches       = 0;
    hold_req         = 0;
    hold_done        = 0;
    hold_left        = 0;
    stall_cycles     = 0;
    tx_idle_pct      = 34;
    rx_idle_pct      = 52;
    dims_sh          = vdp_pkg::DIM_RESET;
    pcount_sh        = '0;
    foreach (queued_words[i]) queued_words[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no pose is in range, so every project reports the range.
    push_project(0, 32'h7fffffff, 32'h80000000, 0);
    push_project(MAX_POSES-1, 0, 0, 0);
    push_project(int'($urandom_range(MAX_POSES-1)), int'($urandom), int'($urandom),
                 int'($urandom));
    // Special poses: ordinary at both ends, zero divisor, zero distance,
    // negative source distance, saturating words.
    load_pose(0, 0);
    load_pose(MAX_POSES-1, 0);
    load_pose(1, 1);
    load_pose(2, 2);
    load_pose(3, 3);
    load_pose(4, 4);
    drain();

    // All poses in range, volume mode: directed projects with extreme voxels.
    cfg_write(vdp_pkg::REG_POSE_COUNT, CNT_W'(MAX_POSES));
    foreach (full_poses[i]) begin
      push_project(full_poses[i], 0, 0, 0);
      push_project(full_poses[i], 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      push_project(full_poses[i], 32'h80000000, 32'h80000000, 32'h80000000);
      push_project(full_poses[i], 1 << 16, -(3 << 16), 5 << 16);
    end
    drain();

    run_phase(2'd3, CNT_W'(MAX_POSES), 220, 34, 52, 1'b0);
    run_phase(vdp_pkg::DIM_PLANAR, CNT_W'(MAX_POSES), 220, 34, 52, 1'b1);
    run_phase(2'd0, CNT_W'(1023), 190, 52, 34, 1'b0);
    run_phase(2'd1, CNT_W'(5), 190, 52, 34, 1'b0);
    run_phase(vdp_pkg::DIM_PLANAR, CNT_W'($urandom_range(0, 600)), 190, 0, 0, 1'b0);
    run_phase(2'd3, CNT_W'(0), 30, 0, 0, 1'b0);
    run_phase(2'd3, CNT_W'($urandom_range(1, 511)), 160, 0, 0, 1'b0);

    if (mismatches == 0 && det_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
